FILE: src/rsrd_pkg.sv
// types, codes and constants shared by the run-length sprite row decoder
package rsrd_pkg;

    // largest value a 9-bit size or clip field can hold
    localparam int DIM_MAX = 511;

    // control byte classes
    localparam logic [7:0] CTRL_FILL = 8'h80;
    localparam logic [7:0] CTRL_SKIP = 8'hC0;
    localparam logic [5:0] RUN_MASK  = 6'h3F;

    // configuration register indexes
    localparam logic [2:0] CFG_SPRITE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SPRITE_ROWS   = 3'd1;
    localparam logic [2:0] CFG_PALETTE_BANK  = 3'd2;
    localparam logic [2:0] CFG_CLIP_LEFT     = 3'd3;
    localparam logic [2:0] CFG_CLIP_RIGHT    = 3'd4;
    localparam logic [2:0] CFG_CLIP_TOP      = 3'd5;
    localparam logic [2:0] CFG_MIRROR_ENABLE = 3'd6;

    typedef enum logic [1:0] {
        PH_CONTROL,
        PH_LITERAL,
        PH_FILL
    } t_phase;

    typedef enum logic {
        ST_RUN,
        ST_FILL
    } t_state;

    typedef struct packed {
        logic [8:0] sprite_width;
        logic [8:0] sprite_rows;
        logic [7:0] palette_bank;
        logic [8:0] clip_left;
        logic [8:0] clip_right;
        logic [8:0] clip_top;
        logic       mirror_enable;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic fill_step;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic lit_write;
        logic fill_go;
        logic fill_vis;
        logic fill_done;
    } t_sts;

endpackage

FILE: src/rsrd_cfg.sv
// configuration register file of the sprite row decoder
module rsrd_cfg
    import rsrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [8:0] i_cfg_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPRITE_WIDTH:  n_cfg.sprite_width  = i_cfg_data;
                CFG_SPRITE_ROWS:   n_cfg.sprite_rows   = i_cfg_data;
                CFG_PALETTE_BANK:  n_cfg.palette_bank  = i_cfg_data[7:0];
                CFG_CLIP_LEFT:     n_cfg.clip_left     = i_cfg_data;
                CFG_CLIP_RIGHT:    n_cfg.clip_right    = i_cfg_data;
                CFG_CLIP_TOP:      n_cfg.clip_top      = i_cfg_data;
                CFG_MIRROR_ENABLE: n_cfg.mirror_enable = i_cfg_data[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/rsrd_ctrl.sv
// controller: beat acceptance, fill sequencing and output register valid
module rsrd_ctrl
    import rsrd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_oval;
    logic   n_oval;
    logic   out_free;
    t_cmd   cmd;

    assign out_free = !r_oval || !i_stall;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_RUN: begin
                cmd.accept   = i_valid && out_free;
                cmd.out_load = cmd.accept && i_sts.lit_write;
                if (cmd.accept && i_sts.fill_go) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.fill_step = out_free;
                cmd.out_load  = out_free && i_sts.fill_vis;
                if (out_free && i_sts.fill_done) begin
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
        n_oval = cmd.out_load || (r_oval && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
        end
    end

    assign o_cmd   = cmd;
    assign o_valid = r_oval;
    assign o_stall = !((r_state == ST_RUN) && out_free);

`ifndef SYNTH
    a_fill_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.accept && i_sts.fill_go) |=> (r_state == ST_FILL))
        else $error("fill run not entered after colour byte");

    a_no_accept_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL) |-> !cmd.accept)
        else $error("byte accepted during fill");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> r_oval)
        else $error("loaded write not presented");
`endif

endmodule

FILE: src/rsrd_dp.sv
// datapath: run decoding, row and column tracking, clipping and output register
module rsrd_dp
    import rsrd_pkg::*;
#(
    parameter int MAX_WIDTH = 512,
    parameter int MAX_ROWS  = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic [7:0] i_stream_byte,
    input  logic       i_sprite_start,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output logic [8:0] o_draw_row,
    output logic [8:0] o_draw_column,
    output logic [7:0] o_pixel_value,
    output logic       o_last_write
);

    localparam int         WCAP  = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
    localparam int         RCAP  = (MAX_ROWS > DIM_MAX) ? DIM_MAX : MAX_ROWS;
    localparam logic [8:0] W_CAP = 9'(WCAP);
    localparam logic [8:0] R_CAP = 9'(RCAP);

    // decoder state
    t_phase      r_phase, n_phase, c_phase;
    logic [6:0]  r_lit, n_lit, c_lit;
    logic [5:0]  r_flen, n_flen, c_flen;
    logic [9:0]  r_col, n_col, c_col;
    logic [8:0]  r_row, n_row, c_row;
    logic        r_fin, n_fin, c_fin;

    // fill engine
    logic [9:0]  r_fcol;
    logic [5:0]  r_fleft;
    logic [7:0]  r_colour;
    logic [8:0]  r_frow;

    // output register
    logic [8:0]  r_draw_row;
    logic [8:0]  r_draw_col;
    logic [7:0]  r_pix;
    logic        r_last;

    // window geometry
    logic [8:0]  eff_w;
    logic [8:0]  eff_rows;
    logic [8:0]  skip;
    logic [10:0] vis;
    logic        vis_pos;
    logic [8:0]  win_s;
    logic [9:0]  win_e;
    logic        row_vis;
    logic        col_vis;
    logic [9:0]  lit_d_fwd;
    logic [9:0]  lit_d_rev;
    logic [9:0]  fill_d_fwd;
    logic [9:0]  fill_d_rev;
    logic [10:0] fcol_nxt;
    logic        run_end;
    logic        lit_write;
    logic        fill_go;
    logic        fill_vis;
    logic        fill_done;

    assign eff_w    = (i_cfg.sprite_width > W_CAP) ? W_CAP : i_cfg.sprite_width;
    assign eff_rows = (i_cfg.sprite_rows > R_CAP) ? R_CAP : i_cfg.sprite_rows;
    assign skip     = (i_cfg.clip_top > eff_rows) ? eff_rows : i_cfg.clip_top;
    assign vis      = {2'b00, eff_w} - {2'b00, i_cfg.clip_left} - {2'b00, i_cfg.clip_right};
    assign vis_pos  = !vis[10] && (vis != 11'd0);
    assign win_s    = i_cfg.mirror_enable ? i_cfg.clip_right : i_cfg.clip_left;
    // one past the last source column in the window
    assign win_e    = i_cfg.mirror_enable ? ({1'b0, eff_w} - {1'b0, i_cfg.clip_left})
                                          : ({1'b0, eff_w} - {1'b0, i_cfg.clip_right});

    // start marker clears the decoder before the byte is decoded
    always_comb begin
        c_phase = r_phase;
        c_lit   = r_lit;
        c_flen  = r_flen;
        c_col   = r_col;
        c_row   = r_row;
        c_fin   = r_fin;
        if (i_sprite_start) begin
            c_phase = PH_CONTROL;
            c_lit   = '0;
            c_flen  = '0;
            c_col   = '0;
            c_row   = '0;
            c_fin   = (eff_w == 9'd0) || (eff_rows == 9'd0);
        end
    end

    assign row_vis   = vis_pos && (c_row >= skip);
    assign col_vis   = (c_col >= {1'b0, win_s}) && (c_col < win_e);
    assign lit_d_fwd = c_col - {1'b0, win_s};
    assign lit_d_rev = win_e - 10'd1 - c_col;

    always_comb begin
        n_phase   = c_phase;
        n_lit     = c_lit;
        n_flen    = c_flen;
        n_col     = c_col;
        n_row     = c_row;
        n_fin     = c_fin;
        run_end   = 1'b0;
        lit_write = 1'b0;
        fill_go   = 1'b0;
        if (!c_fin) begin
            case (c_phase)
                PH_LITERAL: begin
                    lit_write = row_vis && col_vis;
                    n_col     = c_col + 10'd1;
                    n_lit     = c_lit - 7'd1;
                    if (n_lit == 7'd0) begin
                        n_phase = PH_CONTROL;
                        run_end = 1'b1;
                    end
                end
                PH_FILL: begin
                    fill_go = row_vis && (c_flen != 6'd0);
                    n_col   = c_col + {4'b0000, c_flen};
                    n_flen  = '0;
                    n_phase = PH_CONTROL;
                    run_end = 1'b1;
                end
                default: begin
                    n_phase = PH_CONTROL;
                    if (i_stream_byte < CTRL_FILL) begin
                        n_lit = i_stream_byte[6:0];
                        if (i_stream_byte != 8'd0) begin
                            n_phase = PH_LITERAL;
                        end else begin
                            run_end = 1'b1;
                        end
                    end else if (i_stream_byte < CTRL_SKIP) begin
                        n_flen  = i_stream_byte[5:0] & RUN_MASK;
                        n_phase = PH_FILL;
                    end else begin
                        n_col   = c_col + {4'b0000, i_stream_byte[5:0] & RUN_MASK};
                        run_end = 1'b1;
                    end
                end
            endcase
            // row closes once the column reaches the width
            if (run_end && (n_col >= {1'b0, eff_w})) begin
                n_col = '0;
                n_row = c_row + 9'd1;
                if ((n_row >= eff_rows) || (n_row == 9'd0)) begin
                    n_fin = 1'b1;
                end
            end
        end
    end

    // fill engine status
    assign fcol_nxt   = {1'b0, r_fcol} + 11'd1;
    assign fill_vis   = (r_fcol >= {1'b0, win_s}) && (r_fcol < win_e);
    assign fill_done  = (r_fleft == 6'd1) || (fcol_nxt >= {1'b0, win_e});
    assign fill_d_fwd = r_fcol - {1'b0, win_s};
    assign fill_d_rev = win_e - 10'd1 - r_fcol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CONTROL;
            r_lit   <= '0;
            r_flen  <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_fin   <= 1'b1;
        end else if (i_cmd.accept) begin
            r_phase <= n_phase;
            r_lit   <= n_lit;
            r_flen  <= n_flen;
            r_col   <= n_col;
            r_row   <= n_row;
            r_fin   <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_fcol   <= c_col;
            r_fleft  <= c_flen;
            r_colour <= i_stream_byte;
            r_frow   <= c_row - skip;
        end else if (i_cmd.fill_step) begin
            r_fcol  <= fcol_nxt[9:0];
            r_fleft <= r_fleft - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.fill_step) begin
                r_draw_row <= r_frow;
                r_draw_col <= i_cfg.mirror_enable ? fill_d_rev[8:0] : fill_d_fwd[8:0];
                r_pix      <= r_colour + i_cfg.palette_bank;
                r_last     <= fill_done;
            end else begin
                r_draw_row <= c_row - skip;
                r_draw_col <= i_cfg.mirror_enable ? lit_d_rev[8:0] : lit_d_fwd[8:0];
                r_pix      <= i_stream_byte + i_cfg.palette_bank;
                r_last     <= 1'b1;
            end
        end
    end

    assign o_sts.lit_write = lit_write;
    assign o_sts.fill_go   = fill_go;
    assign o_sts.fill_vis  = fill_vis;
    assign o_sts.fill_done = fill_done;

    assign o_draw_row    = r_draw_row;
    assign o_draw_column = r_draw_col;
    assign o_pixel_value = r_pix;
    assign o_last_write  = r_last;

endmodule

FILE: src/rle_sprite_row_decoder_clipped.sv
// top level of the clipped run-length sprite row decoder
//
// channel  direction  handshake          payload
// input    in         i_valid / o_stall  i_stream_byte, i_sprite_start
// output   out        o_valid / i_stall  o_draw_row, o_draw_column, o_pixel_value, o_last_write
// config   in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// control, literal and skipped bytes do not hold off the next byte; a literal pixel lands
// in the output register on the accepting edge
// a colour byte of a non-empty fill on a visible row starts the fill sequencer, which steps
// k pixels, one per cycle while the output is not stalled, until the run ends or passes
// the last window column (k at least 1, at most 63); input is held off until it is done
// synchronous active-low reset clears decoder state, config registers and output valid
// the output register is a single beat; input is taken while it drains, and a stalled
// output holds both the fill sequencer and input acceptance
module rle_sprite_row_decoder_clipped
    import rsrd_pkg::*;
#(
    parameter int MAX_WIDTH = 512,
    parameter int MAX_ROWS  = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // stream beats
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_stream_byte,
    input  logic       i_sprite_start,
    // pixel write beats
    output logic       o_valid,
    input  logic       i_stall,
    output logic [8:0] o_draw_row,
    output logic [8:0] o_draw_column,
    output logic [7:0] o_pixel_value,
    output logic       o_last_write,
    // register writes
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [8:0] i_cfg_data
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    // live register values, read every cycle
    rsrd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // run/fill sequencing and output valid
    rsrd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // decoding, clipping window and the write register
    rsrd_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_stream_byte  (i_stream_byte),
        .i_sprite_start (i_sprite_start),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_draw_row     (o_draw_row),
        .o_draw_column  (o_draw_column),
        .o_pixel_value  (o_pixel_value),
        .o_last_write   (o_last_write)
    );

endmodule
